### design/ssi_pkg.sv
package ssi_pkg;

	// Fixed field widths of the request and result ports.
	localparam int IN_WIDTH  = 32;
	localparam int OUT_WIDTH = 48;

	// Defaults for the top-level parameters.
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

	// Quotient magnitude bits below the sign of a result.
	localparam int QUOT_BITS = OUT_WIDTH - 1;

	// Delay from an accepted request to its done strobe.
	localparam int LATENCY = QUOT_BITS + 10;

endpackage

### design/segment_segment_intersection_core.sv
// Channel  | Handshake      | Fields
// ---------+----------------+-------------------------------------------------
// request  | start, busy    | first_start_x/y, first_end_x/y,
//          |                | second_start_x/y, second_end_x/y
// result   | done (strobe)  | hit, cross_x, cross_y
//
// One request is taken in every cycle; busy stays low.
// Each result passes through nine arithmetic stages, then one divider stage
// per quotient bit for x and y side by side, then the result register.
// Reset clears the valid bits of all stages and the hit output; the other payload registers are not reset.
// The receiver cannot stall, so the pipeline never holds.
module segment_segment_intersection_core
	import ssi_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [IN_WIDTH-1:0]  first_start_x,
	input  logic signed [IN_WIDTH-1:0]  first_start_y,
	input  logic signed [IN_WIDTH-1:0]  first_end_x,
	input  logic signed [IN_WIDTH-1:0]  first_end_y,
	input  logic signed [IN_WIDTH-1:0]  second_start_x,
	input  logic signed [IN_WIDTH-1:0]  second_start_y,
	input  logic signed [IN_WIDTH-1:0]  second_end_x,
	input  logic signed [IN_WIDTH-1:0]  second_end_y,
	output logic                        done,
	output logic                        hit,
	output logic signed [OUT_WIDTH-1:0] cross_x,
	output logic signed [OUT_WIDTH-1:0] cross_y
);

	localparam int W    = COORD_WIDTH;
	localparam int DW   = W + 1;            // coordinate differences
	localparam int PW   = 2 * W + 2;        // products of two differences
	localparam int CW   = 2 * W + 2;        // line constants
	localparam int DETW = 2 * W + 3;        // determinant and cross products
	localparam int LOW  = W + 1;            // low slice of a line constant
	localparam int HIW  = CW - LOW;         // high slice of a line constant
	localparam int PLW  = DW + LOW + 1;     // difference times low slice
	localparam int PHW  = DW + HIW;         // difference times high slice
	localparam int MW   = 3 * W + 3;        // full difference times constant
	localparam int NUMW = 3 * W + 4;        // numerators
	localparam int QB   = QUOT_BITS;
	localparam int NW   = (NUMW + FRAC_BITS > QB) ? NUMW + FRAC_BITS : QB + 1;
	localparam int R0W  = NW - QB;
	localparam int CMPW = (R0W > DETW) ? R0W : DETW;

	localparam logic signed [OUT_WIDTH-1:0] MAXP = {1'b0, {QB{1'b1}}};
	localparam logic signed [OUT_WIDTH-1:0] MINN = {1'b1, {QB{1'b0}}};

	// Requests are never held off.
	assign busy = 1'b0;

	// ---------------------------------------------------------------- stage 1
	logic                v_s1;
	logic signed [W-1:0] sx1_s1, sy1_s1, ex1_s1, ey1_s1;
	logic signed [W-1:0] sx2_s1, sy2_s1, ex2_s1, ey2_s1;

	// Capture the low coordinate bits of each accepted request.
	always_ff @(posedge clk) begin
		sx1_s1 <= first_start_x[W-1:0];
		sy1_s1 <= first_start_y[W-1:0];
		ex1_s1 <= first_end_x[W-1:0];
		ey1_s1 <= first_end_y[W-1:0];
		sx2_s1 <= second_start_x[W-1:0];
		sy2_s1 <= second_start_y[W-1:0];
		ex2_s1 <= second_end_x[W-1:0];
		ey2_s1 <= second_end_y[W-1:0];
	end

	// ---------------------------------------------------------------- stage 2
	logic                 v_s2, box_s2;
	logic signed [DW-1:0] ux_s2, uy_s2, vx_s2, vy_s2, wx_s2, wy_s2;
	logic signed [DW-1:0] px_s2, py_s2, qx_s2, qy_s2;
	logic signed [W-1:0]  sx1_s2, sy1_s2, sx2_s2, sy2_s2;
	logic signed [W-1:0]  max_x1, min_x1, max_y1, min_y1;
	logic signed [W-1:0]  max_x2, min_x2, max_y2, min_y2;

	// Bounding boxes of both segments.
	always_comb begin
		max_x1 = (sx1_s1 > ex1_s1) ? sx1_s1 : ex1_s1;
		min_x1 = (sx1_s1 < ex1_s1) ? sx1_s1 : ex1_s1;
		max_y1 = (sy1_s1 > ey1_s1) ? sy1_s1 : ey1_s1;
		min_y1 = (sy1_s1 < ey1_s1) ? sy1_s1 : ey1_s1;
		max_x2 = (sx2_s1 > ex2_s1) ? sx2_s1 : ex2_s1;
		min_x2 = (sx2_s1 < ex2_s1) ? sx2_s1 : ex2_s1;
		max_y2 = (sy2_s1 > ey2_s1) ? sy2_s1 : ey2_s1;
		min_y2 = (sy2_s1 < ey2_s1) ? sy2_s1 : ey2_s1;
	end

	// Box overlap test and the edge vectors used by all later products.
	always_ff @(posedge clk) begin
		box_s2 <= (max_x1 >= min_x2) && (max_x2 >= min_x1) &&
		          (max_y1 >= min_y2) && (max_y2 >= min_y1);
		ux_s2  <= DW'(ex1_s1) - DW'(sx1_s1);
		uy_s2  <= DW'(ey1_s1) - DW'(sy1_s1);
		vx_s2  <= DW'(ex2_s1) - DW'(sx2_s1);
		vy_s2  <= DW'(ey2_s1) - DW'(sy2_s1);
		wx_s2  <= DW'(sx2_s1) - DW'(sx1_s1);
		wy_s2  <= DW'(sy2_s1) - DW'(sy1_s1);
		px_s2  <= DW'(ex2_s1) - DW'(sx1_s1);
		py_s2  <= DW'(ey2_s1) - DW'(sy1_s1);
		qx_s2  <= DW'(ex1_s1) - DW'(sx2_s1);
		qy_s2  <= DW'(ey1_s1) - DW'(sy2_s1);
		sx1_s2 <= sx1_s1;
		sy1_s2 <= sy1_s1;
		sx2_s2 <= sx2_s1;
		sy2_s2 <= sy2_s1;
	end

	// ---------------------------------------------------------------- stage 3
	logic                 v_s3, box_s3;
	logic signed [PW-1:0] t1a_s3, t1b_s3, t2a_s3, t2b_s3;
	logic signed [PW-1:0] t3a_s3, t3b_s3, t4a_s3, t4b_s3;
	logic signed [PW-1:0] da_s3, db_s3, c1a_s3, c1b_s3, c2a_s3, c2b_s3;
	logic signed [DW-1:0] ux_s3, uy_s3, vx_s3, vy_s3;

	// Products for the straddle tests, the determinant and the line constants.
	always_ff @(posedge clk) begin
		t1a_s3 <= PW'(wx_s2) * PW'(uy_s2);
		t1b_s3 <= PW'(wy_s2) * PW'(ux_s2);
		t2a_s3 <= PW'(ux_s2) * PW'(py_s2);
		t2b_s3 <= PW'(uy_s2) * PW'(px_s2);
		t3a_s3 <= PW'(wy_s2) * PW'(vx_s2);
		t3b_s3 <= PW'(wx_s2) * PW'(vy_s2);
		t4a_s3 <= PW'(vx_s2) * PW'(qy_s2);
		t4b_s3 <= PW'(vy_s2) * PW'(qx_s2);
		da_s3  <= PW'(ux_s2) * PW'(vy_s2);
		db_s3  <= PW'(uy_s2) * PW'(vx_s2);
		c1a_s3 <= PW'(uy_s2) * PW'(sx1_s2);
		c1b_s3 <= PW'(ux_s2) * PW'(sy1_s2);
		c2a_s3 <= PW'(vy_s2) * PW'(sx2_s2);
		c2b_s3 <= PW'(vx_s2) * PW'(sy2_s2);
		box_s3 <= box_s2;
		ux_s3  <= ux_s2;
		uy_s3  <= uy_s2;
		vx_s3  <= vx_s2;
		vy_s3  <= vy_s2;
	end

	// ---------------------------------------------------------------- stage 4
	logic                   v_s4, meet_s4;
	logic signed [DETW-1:0] det_s4;
	logic signed [CW-1:0]   c1_s4, c2_s4;
	logic signed [DW-1:0]   ux_s4, uy_s4, vx_s4, vy_s4;
	logic signed [DETW-1:0] cr1, cr2, cr3, cr4;
	logic                   n1, n2, n3, n4, p1, p2, p3, p4, straddle;

	// Cross products and the straddle decision: the end points of one
	// segment must not lie strictly on the same side of the other.
	always_comb begin
		cr1 = DETW'(t1a_s3) - DETW'(t1b_s3);
		cr2 = DETW'(t2a_s3) - DETW'(t2b_s3);
		cr3 = DETW'(t3a_s3) - DETW'(t3b_s3);
		cr4 = DETW'(t4a_s3) - DETW'(t4b_s3);
		n1 = cr1[DETW-1];
		n2 = cr2[DETW-1];
		n3 = cr3[DETW-1];
		n4 = cr4[DETW-1];
		p1 = !n1 && (cr1 != '0);
		p2 = !n2 && (cr2 != '0);
		p3 = !n3 && (cr3 != '0);
		p4 = !n4 && (cr4 != '0);
		straddle = !((p1 && n2) || (n1 && p2)) && !((p3 && n4) || (n3 && p4));
	end

	always_ff @(posedge clk) begin
		meet_s4 <= box_s3 && straddle;
		det_s4  <= DETW'(da_s3) - DETW'(db_s3);
		c1_s4   <= c1a_s3 - c1b_s3;
		c2_s4   <= c2a_s3 - c2b_s3;
		ux_s4   <= ux_s3;
		uy_s4   <= uy_s3;
		vx_s4   <= vx_s3;
		vy_s4   <= vy_s3;
	end

	// ---------------------------------------------------------------- stage 5
	logic                   v_s5, meet_s5;
	logic signed [DETW-1:0] det_s5;
	logic signed [PLW-1:0]  uxc2l_s5, vxc1l_s5, uyc2l_s5, vyc1l_s5;
	logic signed [PHW-1:0]  uxc2h_s5, vxc1h_s5, uyc2h_s5, vyc1h_s5;
	logic signed [LOW:0]    c1lo, c2lo;
	logic signed [HIW-1:0]  c1hi, c2hi;

	// Split each line constant into an unsigned low and a signed high slice.
	always_comb begin
		c1lo = {1'b0, c1_s4[LOW-1:0]};
		c2lo = {1'b0, c2_s4[LOW-1:0]};
		c1hi = c1_s4[CW-1:LOW];
		c2hi = c2_s4[CW-1:LOW];
	end

	// Partial products of the numerators.
	always_ff @(posedge clk) begin
		uxc2l_s5 <= PLW'(ux_s4) * PLW'(c2lo);
		vxc1l_s5 <= PLW'(vx_s4) * PLW'(c1lo);
		uyc2l_s5 <= PLW'(uy_s4) * PLW'(c2lo);
		vyc1l_s5 <= PLW'(vy_s4) * PLW'(c1lo);
		uxc2h_s5 <= PHW'(ux_s4) * PHW'(c2hi);
		vxc1h_s5 <= PHW'(vx_s4) * PHW'(c1hi);
		uyc2h_s5 <= PHW'(uy_s4) * PHW'(c2hi);
		vyc1h_s5 <= PHW'(vy_s4) * PHW'(c1hi);
		meet_s5  <= meet_s4;
		det_s5   <= det_s4;
	end

	// ---------------------------------------------------------------- stage 6
	logic                   v_s6, meet_s6;
	logic signed [DETW-1:0] det_s6;
	logic signed [MW-1:0]   uxc2_s6, vxc1_s6, uyc2_s6, vyc1_s6;

	// Join the partial products.
	always_ff @(posedge clk) begin
		uxc2_s6 <= (MW'(uxc2h_s5) <<< LOW) + MW'(uxc2l_s5);
		vxc1_s6 <= (MW'(vxc1h_s5) <<< LOW) + MW'(vxc1l_s5);
		uyc2_s6 <= (MW'(uyc2h_s5) <<< LOW) + MW'(uyc2l_s5);
		vyc1_s6 <= (MW'(vyc1h_s5) <<< LOW) + MW'(vyc1l_s5);
		meet_s6 <= meet_s5;
		det_s6  <= det_s5;
	end

	// ---------------------------------------------------------------- stage 7
	logic                   v_s7, meet_s7;
	logic signed [DETW-1:0] det_s7;
	logic signed [NUMW-1:0] nx_s7, ny_s7;

	// Numerators of the crossing point.
	always_ff @(posedge clk) begin
		nx_s7   <= NUMW'(uxc2_s6) - NUMW'(vxc1_s6);
		ny_s7   <= NUMW'(uyc2_s6) - NUMW'(vyc1_s6);
		meet_s7 <= meet_s6;
		det_s7  <= det_s6;
	end

	// ---------------------------------------------------------------- stage 8
	logic            v_s8, hit_s8, negx_s8, negy_s8;
	logic [NUMW-1:0] unx_s8, uny_s8;
	logic [DETW-1:0] ud_s8;

	// Magnitudes and result signs for the unsigned divider.
	always_ff @(posedge clk) begin
		unx_s8  <= nx_s7[NUMW-1] ? NUMW'(-nx_s7) : NUMW'(nx_s7);
		uny_s8  <= ny_s7[NUMW-1] ? NUMW'(-ny_s7) : NUMW'(ny_s7);
		ud_s8   <= det_s7[DETW-1] ? DETW'(-det_s7) : DETW'(det_s7);
		negx_s8 <= nx_s7[NUMW-1] ^ det_s7[DETW-1];
		negy_s8 <= ny_s7[NUMW-1] ^ det_s7[DETW-1];
		hit_s8  <= meet_s7 && (det_s7 != '0);
	end

	// ---------------------------------------------------------------- stage 9
	typedef struct packed {
		logic [DETW-1:0] r_x;
		logic [DETW-1:0] r_y;
		logic [QB-1:0]   n_x;
		logic [QB-1:0]   n_y;
		logic [QB-1:0]   q_x;
		logic [QB-1:0]   q_y;
		logic [DETW-1:0] ud;
		logic            neg_x;
		logic            neg_y;
		logic            sat_x;
		logic            sat_y;
		logic            hit;
	} div_stage_t;

	div_stage_t      div_s[QB+1];
	logic            div_v[QB+1];
	logic [NW-1:0]   fnx, fny;
	logic [R0W-1:0]  r0x, r0y;

	// Scale the numerators; anything at or above the divisor times 2^QB
	// saturates, the rest starts the long division.
	always_comb begin
		fnx = NW'(unx_s8) << FRAC_BITS;
		fny = NW'(uny_s8) << FRAC_BITS;
		r0x = fnx[NW-1:QB];
		r0y = fny[NW-1:QB];
	end

	always_ff @(posedge clk) begin
		div_s[0].r_x   <= DETW'(r0x);
		div_s[0].r_y   <= DETW'(r0y);
		div_s[0].n_x   <= fnx[QB-1:0];
		div_s[0].n_y   <= fny[QB-1:0];
		div_s[0].q_x   <= '0;
		div_s[0].q_y   <= '0;
		div_s[0].ud    <= ud_s8;
		div_s[0].neg_x <= negx_s8;
		div_s[0].neg_y <= negy_s8;
		div_s[0].sat_x <= CMPW'(r0x) >= CMPW'(ud_s8);
		div_s[0].sat_y <= CMPW'(r0y) >= CMPW'(ud_s8);
		div_s[0].hit   <= hit_s8;
	end

	// -------------------------------------------------------- divider stages
	// Each stage settles one quotient bit of x and of y.
	for (genvar k = 1; k <= QB; k++) begin : g_div
		logic [DETW:0] tx, ty;
		logic          gx, gy;

		always_comb begin
			tx = {div_s[k-1].r_x, div_s[k-1].n_x[QB-1]};
			ty = {div_s[k-1].r_y, div_s[k-1].n_y[QB-1]};
			gx = tx >= {1'b0, div_s[k-1].ud};
			gy = ty >= {1'b0, div_s[k-1].ud};
		end

		always_ff @(posedge clk) begin
			div_s[k].r_x   <= gx ? DETW'(tx - {1'b0, div_s[k-1].ud}) : DETW'(tx);
			div_s[k].r_y   <= gy ? DETW'(ty - {1'b0, div_s[k-1].ud}) : DETW'(ty);
			div_s[k].n_x   <= div_s[k-1].n_x << 1;
			div_s[k].n_y   <= div_s[k-1].n_y << 1;
			div_s[k].q_x   <= {div_s[k-1].q_x[QB-2:0], gx};
			div_s[k].q_y   <= {div_s[k-1].q_y[QB-2:0], gy};
			div_s[k].ud    <= div_s[k-1].ud;
			div_s[k].neg_x <= div_s[k-1].neg_x;
			div_s[k].neg_y <= div_s[k-1].neg_y;
			div_s[k].sat_x <= div_s[k-1].sat_x;
			div_s[k].sat_y <= div_s[k-1].sat_y;
			div_s[k].hit   <= div_s[k-1].hit;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v[k] <= 1'b0;
			end else begin
				div_v[k] <= div_v[k-1];
			end
		end
	end

	// ----------------------------------------------------------- result stage
	logic [OUT_WIDTH-1:0]        qx_ext, qy_ext;
	logic signed [OUT_WIDTH-1:0] valx, valy;

	// Apply the sign, saturate, and force zero when there is no hit.
	always_comb begin
		qx_ext = {1'b0, div_s[QB].q_x};
		qy_ext = {1'b0, div_s[QB].q_y};
		if (!div_s[QB].hit) begin
			valx = '0;
		end else if (div_s[QB].sat_x) begin
			valx = div_s[QB].neg_x ? MINN : MAXP;
		end else begin
			valx = div_s[QB].neg_x ? (~qx_ext + OUT_WIDTH'(1)) : qx_ext;
		end
		if (!div_s[QB].hit) begin
			valy = '0;
		end else if (div_s[QB].sat_y) begin
			valy = div_s[QB].neg_y ? MINN : MAXP;
		end else begin
			valy = div_s[QB].neg_y ? (~qy_ext + OUT_WIDTH'(1)) : qy_ext;
		end
	end

	always_ff @(posedge clk) begin
		cross_x <= valx;
		cross_y <= valy;
	end

	// ------------------------------------------------------------ valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			v_s6     <= 1'b0;
			v_s7     <= 1'b0;
			v_s8     <= 1'b0;
			div_v[0] <= 1'b0;
			done     <= 1'b0;
			hit      <= 1'b0;
		end else begin
			v_s1     <= start;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4     <= v_s3;
			v_s5     <= v_s4;
			v_s6     <= v_s5;
			v_s7     <= v_s6;
			v_s8     <= v_s7;
			div_v[0] <= v_s8;
			done     <= div_v[QB];
			hit      <= div_v[QB] && div_s[QB].hit;
		end
	end

endmodule

### design/ssi_checker.sv
module ssi_checker
	import ssi_pkg::*;
(
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic                        hit,
	input logic signed [OUT_WIDTH-1:0] cross_x,
	input logic signed [OUT_WIDTH-1:0] cross_y
);

	// Every accepted request yields a result.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("request produced no result at the expected cycle");

	// No result appears without a matching earlier request.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching request");

	// A miss reports a zero point.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (cross_x == '0 && cross_y == '0))
		else $error("miss with a nonzero crossing point");

	// The hit flag is only shown with the strobe.
	a_hit_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> !hit)
		else $error("hit without done");

endmodule

bind segment_segment_intersection_core ssi_checker u_ssi_checker (.*);
